// ===== rtl/mgcq_pkg.sv =====
// Shared types, constants and helpers of the multilevel grid cell quantizer.
package mgcq_pkg;

  // Parameter defaults
  localparam int LEVELS_DEF    = 3;
  localparam int MAX_GOALS_DEF = 8;

  // Fixed field widths
  localparam int COORD_BITS = 16;
  localparam int SIZE_W     = 16;
  localparam int CELL_W     = 19;   // unsaturated cell point, signed
  localparam int DIFF_W     = 20;   // goal minus cell point, signed
  localparam int SQ_W       = 36;   // sum of squares
  localparam int DIST_W     = 17;
  localparam int CFG_W      = 48;
  localparam int CFG_AW     = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 88;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Iteration counts of the divider and the square root unit
  localparam int DIV_STEPS  = 16;
  localparam int SQRT_STEPS = SQ_W / 2;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_CELL_W = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CELL_H = 3'd1;
  localparam logic [CFG_AW-1:0] REG_THR    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LEVELS = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ORG_X  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ORG_Y  = 3'd5;

  typedef enum logic [1:0] {
    CMD_QUERY     = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_ADD       = 2'd2,
    CMD_QUERY_ALT = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_LOAD, S_DIV, S_SNAP, S_STORE, S_SCAN,
    S_READ, S_SQUARE, S_SUM, S_SQRT, S_CMP, S_NEXT, S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_in;
    logic clr_goals;
    logic div_start;
    logic div_step;
    logic snap;
    logic store;
    logic scan_init;
    logic square;
    logic sum_ld;
    logic sqrt_step;
    logic cmp;
    logic lvl_up;
    logic out_ld;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_add;
    logic no_levels;
    logic div_last;
    logic sqrt_last;
    logic scan_done;
    logic refine;
    logic out_free;
  } dp_stat_t;

  // Clamp a cell point to the signed coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [CELL_W-1:0] v);
    logic signed [CELL_W-1:0] hi;
    logic signed [CELL_W-1:0] lo;
    hi = CELL_W'((1 <<< (COORD_BITS - 1)) - 1);
    lo = -hi - CELL_W'(1);
    if (v > hi) sat_coord = hi[COORD_BITS-1:0];
    else if (v < lo) sat_coord = lo[COORD_BITS-1:0];
    else sat_coord = v[COORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/mgcq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mgcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mgcq_ctrl.sv =====
// Sequencer of the quantizer: steps the datapath through divide, snap, store and goal search, and clears.
module mgcq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  mgcq_pkg::dp_stat_t stat,
  output mgcq_pkg::dp_cmd_t  cmd
);

  mgcq_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mgcq_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      mgcq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = mgcq_pkg::S_START;
        end
      end
      mgcq_pkg::S_START: begin
        if (stat.is_clear) begin
          cmd.clr_goals = 1'b1;
          state_nxt     = mgcq_pkg::S_DONE;
        end else if (stat.no_levels) begin
          state_nxt = mgcq_pkg::S_DONE;
        end else begin
          state_nxt = mgcq_pkg::S_LOAD;
        end
      end
      mgcq_pkg::S_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = mgcq_pkg::S_DIV;
      end
      mgcq_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = mgcq_pkg::S_SNAP;
      end
      mgcq_pkg::S_SNAP: begin
        cmd.snap  = 1'b1;
        state_nxt = stat.is_add ? mgcq_pkg::S_STORE : mgcq_pkg::S_SCAN;
      end
      mgcq_pkg::S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = mgcq_pkg::S_SCAN;
      end
      mgcq_pkg::S_SCAN: begin
        cmd.scan_init = 1'b1;
        state_nxt     = mgcq_pkg::S_READ;
      end
      // goal entry address is presented here, data arrives next cycle
      mgcq_pkg::S_READ: begin
        state_nxt = stat.scan_done ? mgcq_pkg::S_NEXT : mgcq_pkg::S_SQUARE;
      end
      mgcq_pkg::S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = mgcq_pkg::S_SUM;
      end
      mgcq_pkg::S_SUM: begin
        cmd.sum_ld = 1'b1;
        state_nxt  = mgcq_pkg::S_SQRT;
      end
      mgcq_pkg::S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) state_nxt = mgcq_pkg::S_CMP;
      end
      mgcq_pkg::S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = mgcq_pkg::S_READ;
      end
      mgcq_pkg::S_NEXT: begin
        if (stat.refine) begin
          cmd.lvl_up = 1'b1;
          state_nxt  = mgcq_pkg::S_LOAD;
        end else begin
          state_nxt = mgcq_pkg::S_DONE;
        end
      end
      mgcq_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = mgcq_pkg::S_IDLE;
        end
      end
      default: state_nxt = mgcq_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/mgcq_dp.sv =====
// Datapath: config registers, remainder divider, goal table, square root unit, result register.
module mgcq_dp #(
  parameter int LEVELS    = mgcq_pkg::LEVELS_DEF,
  parameter int MAX_GOALS = mgcq_pkg::MAX_GOALS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mgcq_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [mgcq_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [mgcq_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                        in_tuser,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [mgcq_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  mgcq_pkg::dp_cmd_t                 cmd,
  output mgcq_pkg::dp_stat_t                stat
);

  localparam int CNT_W  = $clog2(MAX_GOALS + 1);
  localparam int AW     = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
  localparam int DCNT_W = $clog2(mgcq_pkg::DIV_STEPS);
  localparam int RCNT_W = $clog2(mgcq_pkg::SQRT_STEPS);
  localparam int CW     = mgcq_pkg::CELL_W;
  localparam int SW     = mgcq_pkg::SIZE_W;
  localparam int QW     = mgcq_pkg::SQ_W;
  localparam int DW     = mgcq_pkg::DIST_W;

  // Configuration registers
  logic [47:0]        cw_r, ch_r;
  logic [33:0]        thr_r;
  logic [1:0]         lc_r;
  logic signed [15:0] ox_r, oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= '0;
      ch_r  <= '0;
      thr_r <= '0;
      lc_r  <= '0;
      ox_r  <= '0;
      oy_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mgcq_pkg::REG_CELL_W: cw_r  <= cfg_wdata;
        mgcq_pkg::REG_CELL_H: ch_r  <= cfg_wdata;
        mgcq_pkg::REG_THR:    thr_r <= cfg_wdata[33:0];
        mgcq_pkg::REG_LEVELS: lc_r  <= cfg_wdata[1:0];
        mgcq_pkg::REG_ORG_X:  ox_r  <= cfg_wdata[15:0];
        mgcq_pkg::REG_ORG_Y:  oy_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Levels in use
  logic [1:0] nl;
  assign nl = (lc_r > 2'(LEVELS)) ? 2'(LEVELS) : lc_r;

  // Item registers
  mgcq_pkg::cmd_t     op_r;
  logic signed [15:0] px_r, py_r;
  logic [1:0]         lvl_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r <= mgcq_pkg::cmd_t'(in_tuser);
      px_r <= in_tdata[15:0];
      py_r <= in_tdata[31:16];
      lvl_r <= (mgcq_pkg::cmd_t'(in_tuser) == mgcq_pkg::CMD_ADD && nl != 2'd0) ?
               nl - 2'd1 : 2'd0;
    end else if (cmd.lvl_up) begin
      lvl_r <= lvl_r + 2'd1;
    end
  end

  // Cell size of the current level, zero acting as one
  logic [SW-1:0] wraw, hraw, weff, heff;
  assign wraw = SW'(cw_r >> {lvl_r, 4'd0});
  assign hraw = SW'(ch_r >> {lvl_r, 4'd0});
  assign weff = (wraw == '0) ? SW'(1) : wraw;
  assign heff = (hraw == '0) ? SW'(1) : hraw;

  // Position relative to origin, as sign and magnitude
  logic signed [16:0] relx, rely;
  logic [15:0]        magx, magy;
  assign relx = {px_r[15], px_r} - {ox_r[15], ox_r};
  assign rely = {py_r[15], py_r} - {oy_r[15], oy_r};
  assign magx = relx[16] ? 16'(-relx) : relx[15:0];
  assign magy = rely[16] ? 16'(-rely) : rely[15:0];

  // Restoring remainder divider, both axes side by side
  logic [15:0]       dvdx_r, dvdy_r, magx_r, magy_r, remx_r, remy_r;
  logic [SW-1:0]     szx_r, szy_r, wraw_r, hraw_r;
  logic              negx_r, negy_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [16:0]       tx, ty;
  logic [15:0]       remx_nxt, remy_nxt;

  assign tx = {remx_r, dvdx_r[15]};
  assign ty = {remy_r, dvdy_r[15]};
  assign remx_nxt = (tx >= {1'b0, szx_r}) ? 16'(tx - {1'b0, szx_r}) : tx[15:0];
  assign remy_nxt = (ty >= {1'b0, szy_r}) ? 16'(ty - {1'b0, szy_r}) : ty[15:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvdx_r <= magx;
      dvdy_r <= magy;
      magx_r <= magx;
      magy_r <= magy;
      negx_r <= relx[16];
      negy_r <= rely[16];
      remx_r <= '0;
      remy_r <= '0;
      szx_r  <= weff;
      szy_r  <= heff;
      wraw_r <= wraw;
      hraw_r <= hraw;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dvdx_r <= {dvdx_r[14:0], 1'b0};
      dvdy_r <= {dvdy_r[14:0], 1'b0};
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // Cell point: truncated multiple moved half a cell away from zero
  logic signed [CW-1:0] tmx, tmy, hfx, hfy, cx, cy, cx_r, cy_r;
  assign tmx = CW'(magx_r - remx_r);
  assign tmy = CW'(magy_r - remy_r);
  assign hfx = CW'(szx_r >> 1);
  assign hfy = CW'(szy_r >> 1);
  assign cx  = (negx_r ? -tmx - hfx : tmx + hfx) + CW'(ox_r);
  assign cy  = (negy_r ? -tmy - hfy : tmy + hfy) + CW'(oy_r);

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      cx_r <= cx;
      cy_r <= cy;
    end
  end

  // Goal table
  logic [CNT_W-1:0] count_r, gidx_r;
  logic             full, dropped_r;
  logic [31:0]      gdata;

  assign full = (count_r == CNT_W'(MAX_GOALS));

  mgcq_ram #(.WIDTH(32), .DEPTH(MAX_GOALS)) u_goals (
    .clk   (clk),
    .we    (cmd.store && !full),
    .waddr (count_r[AW-1:0]),
    .wdata ({mgcq_pkg::sat_coord(cy_r), mgcq_pkg::sat_coord(cx_r)}),
    .raddr (gidx_r[AW-1:0]),
    .rdata (gdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr_goals) begin
      count_r <= '0;
    end else if (cmd.store && !full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) dropped_r <= 1'b0;
    else if (cmd.store) dropped_r <= full;
  end

  // Squared distance to one goal
  localparam int DIFF_W_L = mgcq_pkg::DIFF_W;
  logic signed [DIFF_W_L-1:0] dx, dy;
  logic signed [2*DIFF_W_L-1:0] px2, py2;
  logic [QW-1:0] dx2_r, dy2_r;

  assign dx  = DIFF_W_L'($signed(gdata[15:0])) - DIFF_W_L'(cx_r);
  assign dy  = DIFF_W_L'($signed(gdata[31:16])) - DIFF_W_L'(cy_r);
  assign px2 = dx * dx;
  assign py2 = dy * dy;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      dx2_r <= px2[QW-1:0];
      dy2_r <= py2[QW-1:0];
    end
  end

  // Digit by digit square root, two bits of radicand a step
  logic [QW-1:0]     rad_r, root_r, bit_r, rb;
  logic [RCNT_W-1:0] rcnt_r;
  logic [DW-1:0]     dsat, best_r;

  assign rb   = root_r + bit_r;
  assign dsat = (root_r > QW'(mgcq_pkg::DIST_MAX)) ? mgcq_pkg::DIST_MAX : root_r[DW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sum_ld) begin
      rad_r  <= dx2_r + dy2_r;
      root_r <= '0;
      bit_r  <= QW'(1) << (QW - 2);
      rcnt_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (rad_r >= rb) begin
        rad_r  <= rad_r - rb;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r  <= bit_r >> 2;
      rcnt_r <= rcnt_r + RCNT_W'(1);
    end
  end

  // Running minimum over the goals
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      gidx_r <= '0;
      best_r <= mgcq_pkg::DIST_MAX;
    end else if (cmd.cmp) begin
      gidx_r <= gidx_r + CNT_W'(1);
      if (dsat < best_r) best_r <= dsat;
    end
  end

  // Threshold for leaving the current level
  logic [DW-1:0] thr_sel;
  assign thr_sel = (lvl_r == 2'd0) ? thr_r[16:0] : thr_r[33:17];

  // Result register
  logic                              out_valid_r;
  logic [mgcq_pkg::OUT_DATA_W-1:0]   out_data_r, res;

  always_comb begin
    res = '0;
    if (op_r == mgcq_pkg::CMD_CLEAR) begin
      res = '0;
    end else if (nl == 2'd0) begin
      res[15:0]  = px_r;
      res[31:16] = py_r;
    end else begin
      res[15:0]  = mgcq_pkg::sat_coord(cx_r);
      res[31:16] = mgcq_pkg::sat_coord(cy_r);
      res[33:32] = lvl_r;
      res[49:34] = wraw_r;
      res[65:50] = hraw_r;
      res[82:66] = best_r;
      res[83]    = dropped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status
  assign stat.is_clear  = (op_r == mgcq_pkg::CMD_CLEAR);
  assign stat.is_add    = (op_r == mgcq_pkg::CMD_ADD);
  assign stat.no_levels = (nl == 2'd0);
  assign stat.div_last  = (dcnt_r == DCNT_W'(mgcq_pkg::DIV_STEPS - 1));
  assign stat.sqrt_last = (rcnt_r == RCNT_W'(mgcq_pkg::SQRT_STEPS - 1));
  assign stat.scan_done = (gidx_r >= count_r);
  assign stat.refine    = (op_r != mgcq_pkg::CMD_ADD) &&
                          ({1'b0, lvl_r} + 3'd1 < {1'b0, nl}) && (best_r < thr_sel);
  assign stat.out_free  = !out_valid_r || out_tready;

endmodule

// ===== rtl/multilevel_grid_cell_quantizer.sv =====
// Multilevel grid cell quantizer: one item in, one result out, one item at a time.
// A clear, and any item while no levels are in use, goes from acceptance through the start
// and done states into the output register, and the controller then returns to idle. A query
// or an add runs each level it visits through a 16-step remainder divider (both axes side
// by side) and then scans the goal table, reading, squaring and summing each held goal and
// taking its root in the bit-pair square root unit before the compare; an add stores its
// goal before the scan. Up to three levels are visited.
// The next item is accepted as soon as a result is in the output register, even while
// that result still waits to be taken.
module multilevel_grid_cell_quantizer #(
  parameter int LEVELS    = mgcq_pkg::LEVELS_DEF,
  parameter int MAX_GOALS = mgcq_pkg::MAX_GOALS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [mgcq_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [mgcq_pkg::CFG_W-1:0]      cfg_wdata,
  // input beats
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mgcq_pkg::IN_DATA_W-1:0]  in_tdata,  // pos_x[15:0], pos_y[31:16]
  input  logic [1:0]                      in_tuser,  // cmd[1:0]
  // result beats
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mgcq_pkg::OUT_DATA_W-1:0] out_tdata  // cell_x[15:0], cell_y[31:16],
                                                     // level_used[33:32], cell_width[49:34],
                                                     // cell_height[65:50],
                                                     // nearest_distance[82:66],
                                                     // goal_dropped[83], zero[87:84]
);

  mgcq_pkg::dp_cmd_t  cmd;
  mgcq_pkg::dp_stat_t stat;

  mgcq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mgcq_dp #(.LEVELS(LEVELS), .MAX_GOALS(MAX_GOALS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

`ifndef SYNTHESIS
  // one item in flight: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // a result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // a goal is stored right after its cell point is formed
  a_store_after_snap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> $past(cmd.snap))
    else $error("goal stored without fresh cell point");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the multilevel grid cell quantizer.
`timescale 1ns / 1ps

module tb;

  localparam int  NGOALS     = 8;
  localparam int  NLEVELS    = 3;
  localparam int  CYCLE_CAP  = 3000000;
  localparam int  PHASE_BEATS = 75;

  // One result beat, unpacked
  typedef struct packed {
    logic        dropped;
    logic [16:0] distance;
    logic [15:0] height;
    logic [15:0] width;
    logic [1:0]  lvl;
    logic [15:0] cy;
    logic [15:0] cx;
  } cell_res_t;

  // Directed stimulus row; known holds a typed-in expected result
  typedef struct {
    mgcq_pkg::cmd_t cmd;
    logic [15:0]    x;
    logic [15:0]    y;
    bit             known;
    logic [83:0]    res;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [mgcq_pkg::CFG_AW-1:0]     cfg_addr;
  logic [mgcq_pkg::CFG_W-1:0]      cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [mgcq_pkg::IN_DATA_W-1:0]  in_tdata;   // pos_x[15:0], pos_y[31:16]
  logic [1:0]                      in_tuser;   // cmd[1:0]
  logic                            out_tvalid;
  logic                            out_tready;
  logic [mgcq_pkg::OUT_DATA_W-1:0] out_tdata;  // cell_x, cell_y, level_used, cell_width,
                                               // cell_height, nearest_distance, goal_dropped

  multilevel_grid_cell_quantizer i_dut (.*);

  // Shadow of the block's registers and goal table
  logic [47:0] m_cw, m_ch;
  logic [33:0] m_thr;
  logic [1:0]  m_lc;
  logic [15:0] m_ox, m_oy;
  longint      m_gx [NGOALS];
  longint      m_gy [NGOALS];
  int          m_gcnt;

  cell_res_t   pending_cells[$];
  stim_row_t   rows[$];
  int          fails;
  int          cycles;
  int          snd_pct, rcv_pct;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fails++;
  endtask

  function automatic cell_res_t unpack_cell(input logic [83:0] v);
    return cell_res_t'(v);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Cell point on one axis: mean of truncated and away-from-zero multiples
  function automatic longint snap(input longint p, input longint o, input longint s);
    longint rel, t, a;
    rel = p - o;
    t = (rel / s) * s;
    a = (rel >= 0) ? t + s : t - s;
    return (t + a) / 2 + o;
  endfunction

  function automatic longint clamp16(input longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic logic [16:0] nearest_goal(input longint cx, input longint cy);
    longint unsigned best, d;
    longint dx, dy;
    best = 131071;
    for (int i = 0; i < m_gcnt; i++) begin
      dx = m_gx[i] - cx;
      dy = m_gy[i] - cy;
      d = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
      if (d < best) best = d;
    end
    return best[16:0];
  endfunction

  function automatic longint size_at(input logic [47:0] sizes, input int lvl,
                                     output logic [15:0] raw);
    raw = sizes[16*lvl +: 16];
    return raw == 0 ? 1 : longint'(raw);
  endfunction

  // Expected result of one beat; updates the goal table
  function automatic cell_res_t quantize(input mgcq_pkg::cmd_t cmd, input logic [15:0] x,
                                         input logic [15:0] y);
    cell_res_t r;
    longint px, py, ox, oy, cx, cy, sw, sh;
    int nl, idx;
    logic [16:0] d;
    r = '0;
    px = longint'($signed(x));
    py = longint'($signed(y));
    ox = longint'($signed(m_ox));
    oy = longint'($signed(m_oy));
    nl = (m_lc > NLEVELS) ? NLEVELS : m_lc;
    cx = px;
    cy = py;
    if (cmd == mgcq_pkg::CMD_CLEAR) begin
      m_gcnt = 0;
      return r;
    end
    if (nl != 0 && cmd == mgcq_pkg::CMD_ADD) begin
      r.lvl = 2'(nl - 1);
      sw = size_at(m_cw, nl - 1, r.width);
      sh = size_at(m_ch, nl - 1, r.height);
      cx = snap(px, ox, sw);
      cy = snap(py, oy, sh);
      if (m_gcnt < NGOALS) begin
        m_gx[m_gcnt] = clamp16(cx);
        m_gy[m_gcnt] = clamp16(cy);
        m_gcnt++;
      end else begin
        r.dropped = 1'b1;
      end
      r.distance = nearest_goal(cx, cy);
    end else if (nl != 0) begin
      // refine while the nearest goal is closer than the level threshold
      idx = 0;
      forever begin
        sw = size_at(m_cw, idx, r.width);
        sh = size_at(m_ch, idx, r.height);
        cx = snap(px, ox, sw);
        cy = snap(py, oy, sh);
        d = nearest_goal(cx, cy);
        idx++;
        if (idx >= nl) break;
        if (!(d < m_thr[17*(idx-1) +: 17])) break;
      end
      r.lvl = 2'(idx - 1);
      r.distance = d;
    end
    r.cx = 16'(clamp16(cx));
    r.cy = 16'(clamp16(cy));
    return r;
  endfunction

  task automatic write_reg(input logic [mgcq_pkg::CFG_AW-1:0] a,
                           input logic [mgcq_pkg::CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    case (a)
      mgcq_pkg::REG_CELL_W: m_cw  = d[47:0];
      mgcq_pkg::REG_CELL_H: m_ch  = d[47:0];
      mgcq_pkg::REG_THR:    m_thr = d[33:0];
      mgcq_pkg::REG_LEVELS: m_lc  = d[1:0];
      mgcq_pkg::REG_ORG_X:  m_ox  = d[15:0];
      mgcq_pkg::REG_ORG_Y:  m_oy  = d[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [47:0] cw, input logic [47:0] ch,
                           input logic [33:0] thr, input logic [1:0] lc,
                           input logic [15:0] ox, input logic [15:0] oy);
    write_reg(mgcq_pkg::REG_CELL_W, cw);
    write_reg(mgcq_pkg::REG_CELL_H, ch);
    write_reg(mgcq_pkg::REG_THR, 48'(thr));
    write_reg(mgcq_pkg::REG_LEVELS, 48'(lc));
    write_reg(mgcq_pkg::REG_ORG_X, 48'(ox));
    write_reg(mgcq_pkg::REG_ORG_Y, 48'(oy));
    cfg_we <= 1'b0;
  endtask

  // Append one directed row
  task automatic add_row(input mgcq_pkg::cmd_t c, input logic [15:0] x,
                         input logic [15:0] y, input bit known, input logic [83:0] res);
    rows.insert(rows.size(), '{c, x, y, known, res});
  endtask

  // Drive one beat; known/res override the predicted result
  task automatic send(input mgcq_pkg::cmd_t cmd, input logic [15:0] x,
                      input logic [15:0] y, input bit known, input logic [83:0] res);
    cell_res_t p;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = quantize(cmd, x, y);
    pending_cells.insert(pending_cells.size(), known ? unpack_cell(res) : p);
    if ($urandom_range(99) < snd_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver stalls
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rcv_pct);

  // Result checker
  always @(posedge clk) begin
    cell_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_cell(out_tdata[83:0]);
      if (pending_cells.size() == 0) begin
        report("unexpected result beat", 1, 0);
      end else begin
        want = pending_cells.pop_front();
        if (got.cx != want.cx) report("cell_x", $signed(got.cx), $signed(want.cx));
        if (got.cy != want.cy) report("cell_y", $signed(got.cy), $signed(want.cy));
        if (got.lvl != want.lvl) report("level_used", got.lvl, want.lvl);
        if (got.width != want.width) report("cell_width", got.width, want.width);
        if (got.height != want.height) report("cell_height", got.height, want.height);
        if (got.distance != want.distance)
          report("nearest_distance", got.distance, want.distance);
        if (got.dropped != want.dropped) report("goal_dropped", got.dropped, want.dropped);
      end
    end
  end

  function automatic logic [15:0] rand_size();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'd0;
    if (k == 1) return 16'hFFFF;
    if (k == 2) return 16'($urandom_range(1, 5000));
    return 16'($urandom_range(1, 200));
  endfunction

  initial begin
    int          snd_tab[4] = '{0, 63, 0, 17};
    int          rcv_tab[4] = '{0, 0, 63, 17};
    int          sent, ngoal, k;
    logic [15:0] cxr, cyr, gx, gy;
    logic [1:0]  lc;
    logic [33:0] thr;

    snd_pct = 0; rcv_pct = 0;
    m_cw = '0; m_ch = '0; m_thr = '0; m_lc = '0; m_ox = '0; m_oy = '0; m_gcnt = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No levels after reset: positions pass through except on a clear, other fields zero
    add_row(mgcq_pkg::CMD_QUERY, 16'h7FFF, 16'h8000, 1, {52'd0, 16'h8000, 16'h7FFF});
    add_row(mgcq_pkg::CMD_CLEAR, 16'h1234, 16'h5678, 1, 84'd0);
    add_row(mgcq_pkg::CMD_ADD, 16'h8000, 16'h7FFF, 1, {52'd0, 16'h7FFF, 16'h8000});
    add_row(mgcq_pkg::CMD_QUERY_ALT, 16'h0000, 16'hFFFF, 1, {52'd0, 16'hFFFF, 16'h0000});
    foreach (rows[i]) send(rows[i].cmd, rows[i].x, rows[i].y, rows[i].known, rows[i].res);
    drain();

    // Three levels, extreme origin and sizes, zero sizes at some levels
    configure({16'd0, 16'd100, 16'hFFFF}, {16'd3, 16'd0, 16'd40000},
              {17'h1FFFF, 17'd500}, 2'd3, 16'h8000, 16'h7FFF);
    rows.delete();
    add_row(mgcq_pkg::CMD_QUERY, 16'h0000, 16'h0000, 0, '0);  // no goals
    add_row(mgcq_pkg::CMD_QUERY, 16'h7FFF, 16'h8000, 0, '0);
    for (int i = 0; i < 9; i++)                                // last add is dropped
      add_row(mgcq_pkg::CMD_ADD, 16'(i * 7 - 20), 16'(i * 5 + 3), 0, '0);
    add_row(mgcq_pkg::CMD_QUERY, 16'h0010, 16'h0004, 0, '0);
    add_row(mgcq_pkg::CMD_QUERY_ALT, 16'hFFF0, 16'h0020, 0, '0);
    add_row(mgcq_pkg::CMD_QUERY, 16'h7FFF, 16'h7FFF, 0, '0);  // saturation
    add_row(mgcq_pkg::CMD_QUERY, 16'h8000, 16'h8000, 0, '0);
    add_row(mgcq_pkg::CMD_ADD, 16'h7FFF, 16'h8000, 0, '0);
    add_row(mgcq_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 0, '0);
    add_row(mgcq_pkg::CMD_ADD, 16'h8000, 16'h7FFF, 0, '0);
    add_row(mgcq_pkg::CMD_QUERY, 16'h8001, 16'h7FFE, 0, '0);
    foreach (rows[i]) send(rows[i].cmd, rows[i].x, rows[i].y, rows[i].known, rows[i].res);
    drain();

    // Random phases over settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      snd_pct = snd_tab[ph % 4];
      rcv_pct = rcv_tab[ph % 4];
      lc = (ph < 4) ? 2'(3 - ph) : 2'($urandom_range(1, 3));
      thr[16:0]  = ($urandom_range(4) == 0) ? 17'h1FFFF : 17'($urandom_range(0, 2000));
      thr[33:17] = ($urandom_range(4) == 0) ? 17'h1FFFF : 17'($urandom_range(0, 600));
      configure({rand_size(), rand_size(), rand_size()},
                {rand_size(), rand_size(), rand_size()},
                thr, lc, 16'($urandom), 16'($urandom));
      sent = 0;
      while (sent < PHASE_BEATS) begin
        k = $urandom_range(9);
        if (k < 2) begin
          // noise: any command, any position
          send(mgcq_pkg::cmd_t'($urandom_range(3)), 16'($urandom), 16'($urandom), 0, '0);
          sent++;
        end else begin
          // clear (skipped when k is 2), zero to nine goals around a center, then queries nearby
          cxr = 16'($urandom);
          cyr = 16'($urandom);
          if (k != 2) begin
            send(mgcq_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 0, '0);
            sent++;
          end
          ngoal = $urandom_range(0, 9);
          for (int g = 0; g < ngoal; g++) begin
            gx = cxr + 16'($urandom_range(0, 600)) - 16'd300;
            gy = cyr + 16'($urandom_range(0, 600)) - 16'd300;
            send(mgcq_pkg::CMD_ADD, gx, gy, 0, '0);
            sent++;
          end
          for (int q = $urandom_range(2, 6); q > 0; q--) begin
            send(($urandom_range(7) == 0) ? mgcq_pkg::CMD_QUERY_ALT : mgcq_pkg::CMD_QUERY,
                 cxr + 16'($urandom_range(0, 1000)) - 16'd500,
                 cyr + 16'($urandom_range(0, 1000)) - 16'd500, 0, '0);
            sent++;
          end
        end
      end
      drain();
    end

    snd_pct = 0;
    rcv_pct = 0;
    repeat (700) @(posedge clk);
    if (pending_cells.size() != 0) begin
      report("results never arrived", pending_cells.size(), 0);
    end
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mgcq_pkg.sv
rtl/mgcq_ram.sv
rtl/mgcq_ctrl.sv
rtl/mgcq_dp.sv
rtl/multilevel_grid_cell_quantizer.sv
test/tb.sv
